### rtl/bcu_pkg.sv
// Shared constants, types and state encodings of the binomial coefficient unit.
`timescale 1ns / 1ps
`default_nettype none

package bcu_pkg;

	localparam int RESULT_WIDTH_DEF = 64;
	localparam int ARG_WIDTH_DEF    = 32;

	// Fixed field widths of the stream words.
	localparam int POP_W       = 32;
	localparam int CHOOSE_W    = 32;
	localparam int COEF_W      = 64;
	localparam int IN_TDATA_W  = POP_W + CHOOSE_W;
	localparam int OUT_TDATA_W = 72;
	localparam int OUT_PAD_W   = OUT_TDATA_W - COEF_W - 1;

	// Partial products of the shared multiplier are this many bits of b wide.
	localparam int CHUNK_W = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_START,
		ST_WAIT,
		ST_FINISH
	} bcu_state_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV,
		MD_DONE
	} bcu_md_state_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} bcu_md_status_t;

endpackage

`default_nettype wire

### rtl/binomial_coefficient_unit.sv
// Top level of the binomial coefficient unit: sequencer, loop state and output register.
// When k is 0, equals n or exceeds n, the result is set directly; otherwise the unit runs
// one round of the shared multiply-divide unit per i = 1..min(k, n-k), b = b * (base + i) / i;
// overflow ends the loop early. A stalled output word holds the unit until it is taken.
// One word at a time: a new input is accepted only once the result is in the output register.
// Reset clears the sequencer and the output valid flag; there is no stored state to clear.
`timescale 1ns / 1ps
`default_nettype none

module binomial_coefficient_unit #(
	parameter int RESULT_WIDTH = bcu_pkg::RESULT_WIDTH_DEF,
	parameter int ARG_WIDTH    = bcu_pkg::ARG_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// [31:0] pop_size, [63:32] choose_count
	input  wire logic [bcu_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// [63:0] coefficient, [64] overflow, [71:65] zero
	output logic [bcu_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
	import bcu_pkg::*;

	localparam logic [RESULT_WIDTH-1:0] RES_MAX = '1;

	bcu_state_t              state_q, state_d;
	logic [ARG_WIDTH-1:0]    n_q;
	logic [ARG_WIDTH-1:0]    k_q;
	logic [ARG_WIDTH-1:0]    base_q;
	logic [ARG_WIDTH-1:0]    i_q;
	logic [RESULT_WIDTH-1:0] b_q;
	logic [RESULT_WIDTH-1:0] res_q;
	logic                    res_ovf_q;
	logic                    out_valid_q;
	logic [COEF_W-1:0]       out_coef_q;
	logic                    out_ovf_q;

	logic                    md_start;
	logic                    out_load;
	logic [ARG_WIDTH-1:0]    diff;
	logic [ARG_WIDTH-1:0]    md_m;
	logic [RESULT_WIDTH-1:0] md_q;
	bcu_md_status_t          md_st;

	assign diff = n_q - k_q;
	assign md_m = base_q + i_q;

	bcu_muldiv #(
		.RESULT_WIDTH(RESULT_WIDTH),
		.ARG_WIDTH   (ARG_WIDTH)
	) u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (md_start),
		.b     (b_q),
		.m     (md_m),
		.d     (i_q),
		.status(md_st),
		.q     (md_q)
	);

	always_comb begin
		state_d       = state_q;
		md_start      = 1'b0;
		out_load      = 1'b0;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				if (k_q == '0 || k_q == n_q || k_q > n_q) state_d = ST_FINISH;
				else state_d = ST_START;
			end
			ST_START: begin
				md_start = 1'b1;
				state_d  = ST_WAIT;
			end
			ST_WAIT: begin
				if (md_st.done) begin
					if (md_st.ovf || i_q == k_q) state_d = ST_FINISH;
					else state_d = ST_START;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Every partial value is itself a binomial coefficient and never shrinks,
	// so a partial value past the result width already means overflow.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					n_q <= s_axis_tdata[ARG_WIDTH-1:0];
					k_q <= s_axis_tdata[POP_W +: ARG_WIDTH];
				end
			end
			ST_SETUP: begin
				res_ovf_q <= 1'b0;
				if (k_q == '0 || k_q == n_q) begin
					res_q <= RESULT_WIDTH'(1);
				end else if (k_q > n_q) begin
					res_q <= '0;
				end else begin
					if (k_q > diff) begin
						k_q    <= diff;
						base_q <= k_q;
					end else begin
						base_q <= diff;
					end
					b_q <= RESULT_WIDTH'(1);
					i_q <= ARG_WIDTH'(1);
				end
			end
			ST_WAIT: begin
				if (md_st.done) begin
					if (md_st.ovf) begin
						res_q     <= RES_MAX;
						res_ovf_q <= 1'b1;
					end else begin
						b_q <= md_q;
						if (i_q == k_q) res_q <= md_q;
						else i_q <= i_q + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_coef_q <= COEF_W'(res_q);
			out_ovf_q  <= res_ovf_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_ovf_q, out_coef_q};

`ifndef SYNTHESIS
	a_ovf_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_ovf_q |-> out_coef_q == COEF_W'(RES_MAX))
		else $error("overflow word without saturated coefficient");
	a_loop_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WAIT |-> i_q != '0 && i_q <= k_q)
		else $error("loop index out of range");
	a_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		md_st.done |-> state_q == ST_WAIT)
		else $error("multiply-divide result while not waiting");
	a_k_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_START |-> k_q <= base_q)
		else $error("choice count not reduced to the smaller side");
`endif

endmodule

`default_nettype wire

### rtl/bcu_muldiv.sv
// Shared multiply-divide unit: computes the integer quotient b * m / d, multiply then divide.
`timescale 1ns / 1ps
`default_nettype none

module bcu_muldiv #(
	parameter int RESULT_WIDTH = bcu_pkg::RESULT_WIDTH_DEF,
	parameter int ARG_WIDTH    = bcu_pkg::ARG_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [RESULT_WIDTH-1:0] b,
	input  wire logic [ARG_WIDTH-1:0]    m,
	input  wire logic [ARG_WIDTH-1:0]    d,
	output bcu_pkg::bcu_md_status_t      status,
	output logic      [RESULT_WIDTH-1:0] q
);
	import bcu_pkg::*;

	localparam int NCH = (RESULT_WIDTH + CHUNK_W - 1) / CHUNK_W;
	localparam int BW  = NCH * CHUNK_W;
	localparam int PW  = RESULT_WIDTH + ARG_WIDTH;
	localparam int PPW = CHUNK_W + ARG_WIDTH;
	localparam int MCW = $clog2(NCH + 1);
	localparam int DCW = $clog2(PW);

	bcu_md_state_t          state_q, state_d;
	logic [MCW-1:0]         mc_q;
	logic [DCW-1:0]         dc_q;
	logic [BW-1:0]          bsh_q;
	logic [ARG_WIDTH-1:0]   m_q;
	logic [ARG_WIDTH-1:0]   d_q;
	logic [PPW-1:0]         pp_q;
	logic [PW-1:0]          acc_q;
	logic [ARG_WIDTH-1:0]   rem_q;

	logic [CHUNK_W-1:0]     chunk;
	logic [PPW-1:0]         pp_d;
	logic [ARG_WIDTH:0]     rsh;
	logic [ARG_WIDTH:0]     rdiff;
	logic                   ge;

	assign chunk = bsh_q[BW-1 -: CHUNK_W];
	assign pp_d  = PPW'(chunk) * PPW'(m_q);
	assign rsh   = {rem_q, acc_q[PW-1]};
	assign rdiff = rsh - {1'b0, d_q};
	assign ge    = (rsh >= {1'b0, d_q});

	always_comb begin
		state_d = state_q;
		case (state_q)
			MD_IDLE: begin
				if (start) state_d = MD_MUL;
			end
			MD_MUL: begin
				if (mc_q == MCW'(NCH)) state_d = MD_DIV;
			end
			MD_DIV: begin
				if (dc_q == DCW'(PW - 1)) state_d = MD_DONE;
			end
			MD_DONE: begin
				state_d = MD_IDLE;
			end
			default: begin
				state_d = MD_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			mc_q    <= '0;
			dc_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == MD_IDLE) begin
				mc_q <= '0;
				dc_q <= '0;
			end else if (state_q == MD_MUL) begin
				mc_q <= mc_q + 1'b1;
			end else if (state_q == MD_DIV) begin
				dc_q <= dc_q + 1'b1;
			end
		end
	end

	// The product is built from the top 32-bit chunk of b down, one partial
	// product per cycle, then restoring division shifts the quotient into acc_q.
	always_ff @(posedge clk) begin
		case (state_q)
			MD_IDLE: begin
				if (start) begin
					bsh_q <= BW'(b);
					m_q   <= m;
					d_q   <= d;
					acc_q <= '0;
					rem_q <= '0;
				end
			end
			MD_MUL: begin
				if (mc_q < MCW'(NCH)) begin
					pp_q  <= pp_d;
					bsh_q <= bsh_q << CHUNK_W;
				end
				if (mc_q != '0) begin
					acc_q <= (acc_q << CHUNK_W) + PW'(pp_q);
				end
			end
			MD_DIV: begin
				rem_q <= ge ? rdiff[ARG_WIDTH-1:0] : rsh[ARG_WIDTH-1:0];
				acc_q <= {acc_q[PW-2:0], ge};
			end
			default: begin
			end
		endcase
	end

	assign status.done = (state_q == MD_DONE);
	assign status.ovf  = |acc_q[PW-1:RESULT_WIDTH];
	assign q           = acc_q[RESULT_WIDTH-1:0];

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == MD_IDLE)
		else $error("multiply-divide started while busy");
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == MD_DIV |-> rem_q < d_q)
		else $error("division remainder not below divisor");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == MD_DIV |-> d_q != '0)
		else $error("division by zero");
`endif

endmodule

`default_nettype wire
